/* design/button_countdown_timer_assert.svh */
// assertion macros shared by the checker of the button countdown timer
// expects aclk and aresetn in the scope where the macros are used
`ifndef BUTTON_COUNTDOWN_TIMER_ASSERT_SVH
`define BUTTON_COUNTDOWN_TIMER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define BCT_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |-> (prop)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define BCT_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (prop)) else $error(msg);

`endif

/* design/bct_pkg.sv */
// types, constants and helpers for the button countdown timer
// no dependencies
package bct_pkg;

    localparam int LIMIT_W = 32;
    localparam int TIME_W  = 6;
    localparam int BTN_W   = 3;

    localparam logic [LIMIT_W-1:0] LONG_PRESS_RESET = 32'd64000;
    localparam logic [TIME_W-1:0]  TIME_MAX         = 6'd59;

    // pressed-button patterns (active high, bit0 is button 1)
    localparam logic [BTN_W-1:0] PRESS_NONE = 3'b000;
    localparam logic [BTN_W-1:0] PRESS_B1   = 3'b001;
    localparam logic [BTN_W-1:0] PRESS_B2   = 3'b010;
    localparam logic [BTN_W-1:0] PRESS_B3   = 3'b100;

    typedef struct packed {
        logic             period_tick;
        logic [BTN_W-1:0] buttons_n;
    } item_t;

    typedef struct packed {
        logic              show_time;
        logic              alarm_raised;
        logic              led_on;
        logic [TIME_W-1:0] seconds_shown;
        logic [TIME_W-1:0] minutes_shown;
    } result_t;

    function automatic logic [TIME_W-1:0] advance_wrap(input logic [TIME_W-1:0] v);
        advance_wrap = (v >= TIME_MAX) ? '0 : v + 1'b1;
    endfunction

endpackage

/* design/bct_in_stage.sv */
// input register of the button countdown timer
// depends on bct_pkg
module bct_in_stage
    import bct_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  item_t s_item,
    input  logic  take,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    item_t item_reg;

    // free slot, or the held word leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

endmodule

/* design/bct_core.sv */
// timer state and the one-step update for each sampled word
// depends on bct_pkg
module bct_core
    import bct_pkg::*;
#(
    parameter int HOLD_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic [LIMIT_W-1:0] cfg_data,
    input  logic               step,
    input  item_t              item,
    output result_t            result
);

    localparam int CMP_W = (HOLD_BITS > LIMIT_W) ? HOLD_BITS : LIMIT_W;

    logic [LIMIT_W-1:0]   limit_reg;
    logic [TIME_W-1:0]    min_reg, min_next;
    logic [TIME_W-1:0]    sec_reg, sec_next;
    logic                 run_reg, run_next;
    logic                 alarm_reg, alarm_next;
    logic                 rep_reg, rep_next;
    logic                 led_reg, led_next;
    logic                 hold_act_reg, hold_act_next;
    logic [HOLD_BITS-1:0] hold_cnt_reg, hold_cnt_next;
    logic                 show;

    logic [BTN_W-1:0]  pressed;
    logic              short_hold;
    logic [TIME_W-1:0] min_dn, sec_dn;

    assign pressed    = ~item.buttons_n;
    assign short_hold = CMP_W'(hold_cnt_reg) <= CMP_W'(limit_reg);

    // countdown with borrow, sticking at 00:00
    assign min_dn = (sec_reg == '0 && min_reg != '0) ? min_reg - 1'b1 : min_reg;
    assign sec_dn = (sec_reg != '0) ? sec_reg - 1'b1 :
                    (min_reg != '0) ? TIME_MAX : sec_reg;

    always_comb begin
        min_next      = min_reg;
        sec_next      = sec_reg;
        run_next      = run_reg;
        alarm_next    = alarm_reg;
        rep_next      = rep_reg;
        led_next      = led_reg;
        hold_act_next = hold_act_reg;
        hold_cnt_next = hold_cnt_reg;
        show          = 1'b0;
        if (pressed == PRESS_NONE && hold_act_reg) begin
            // button 3 released
            if (short_hold) begin
                run_next = !run_reg;
                if (run_reg) begin
                    led_next = 1'b0;
                    rep_next = 1'b0;
                end
                alarm_next = 1'b0;
            end else begin
                run_next   = 1'b0;
                alarm_next = 1'b0;
                rep_next   = 1'b0;
                min_next   = '0;
                sec_next   = '0;
                show       = 1'b1;
            end
            hold_act_next = 1'b0;
            hold_cnt_next = '0;
        end else begin
            if (hold_act_reg && hold_cnt_reg != '1) begin
                hold_cnt_next = hold_cnt_reg + 1'b1;
            end
            case (pressed)
                PRESS_B1: begin
                    run_next   = 1'b0;
                    alarm_next = 1'b0;
                    led_next   = 1'b0;
                    rep_next   = 1'b0;
                    if (item.period_tick) begin
                        min_next = advance_wrap(min_reg);
                        show     = 1'b1;
                    end
                end
                PRESS_B2: begin
                    run_next   = 1'b0;
                    alarm_next = 1'b0;
                    led_next   = 1'b0;
                    rep_next   = 1'b0;
                    if (item.period_tick) begin
                        sec_next = advance_wrap(sec_reg);
                        show     = 1'b1;
                    end
                end
                PRESS_B3: begin
                    if (!hold_act_reg) begin
                        hold_act_next = 1'b1;
                        hold_cnt_next = '0;
                    end
                end
                PRESS_NONE: begin
                    if (item.period_tick && run_reg && !rep_reg) begin
                        min_next = min_dn;
                        sec_next = sec_dn;
                        led_next = alarm_reg ? 1'b1 : !led_reg;
                        show     = 1'b1;
                        if (min_dn == '0 && sec_dn == '0) begin
                            alarm_next = 1'b1;
                            rep_next   = 1'b1;
                            led_next   = 1'b1;
                        end
                    end
                end
                default: begin
                    // several buttons at once
                    run_next   = 1'b0;
                    alarm_next = 1'b0;
                    led_next   = 1'b0;
                    rep_next   = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        result.minutes_shown = min_next;
        result.seconds_shown = sec_next;
        result.led_on        = led_next;
        result.alarm_raised  = alarm_next;
        result.show_time     = show;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LONG_PRESS_RESET;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg      <= '0;
            sec_reg      <= '0;
            run_reg      <= 1'b0;
            alarm_reg    <= 1'b0;
            rep_reg      <= 1'b0;
            led_reg      <= 1'b0;
            hold_act_reg <= 1'b0;
            hold_cnt_reg <= '0;
        end else if (step) begin
            min_reg      <= min_next;
            sec_reg      <= sec_next;
            run_reg      <= run_next;
            alarm_reg    <= alarm_next;
            rep_reg      <= rep_next;
            led_reg      <= led_next;
            hold_act_reg <= hold_act_next;
            hold_cnt_reg <= hold_cnt_next;
        end
    end

endmodule

/* design/bct_out_stage.sv */
// result register of the button countdown timer
// depends on bct_pkg
module bct_out_stage
    import bct_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t result,
    output logic    space,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_result
);

    logic    valid_reg;
    result_t result_reg;

    // room when empty or the waiting word is taken now
    assign space    = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (space) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && space) begin
            result_reg <= result;
        end
    end

endmodule

/* design/button_countdown_timer.sv */
// Button countdown timer, minutes:seconds. Each input word is one debounced
// sample of three active-low buttons plus the one-second tick flag, and gives
// exactly one result word with the time, LED, alarm and a display flag. One
// word is taken every clock cycle unless the output stalls; a result passes
// the input register, then the result register; the rate is set by the timer
// state update, combinational between them. The user must write the long-press
// limit through the cfg port while the block idles; the block does not enforce it.
// depends on bct_pkg, bct_in_stage, bct_core, bct_out_stage
module button_countdown_timer
    import bct_pkg::*;
#(
    parameter int HOLD_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data,   // long_press_limit
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,    // buttons_n[2:0], period_tick[3], zero pad
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata     // minutes_shown[5:0], seconds_shown[11:6],
                                           // led_on[12], alarm_raised[13],
                                           // show_time[14], zero pad
);

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    space;
    logic    step;
    result_t result;
    result_t m_result;

    assign cfg_ready = 1'b1;
    assign s_item    = s_tdata[$bits(item_t)-1:0];
    assign step      = item_valid && space;
    assign m_tdata   = {1'b0, m_result};

    bct_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (space),
        .item_valid (item_valid),
        .item       (item)
    );

    bct_core #(
        .HOLD_BITS (HOLD_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .step      (step),
        .item      (item),
        .result    (result)
    );

    bct_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step),
        .result   (result),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

endmodule

/* design/bct_checker.sv */
// port-level checks for the button countdown timer, bound to the top level
// depends on button_countdown_timer_assert.svh
`include "button_countdown_timer_assert.svh"

module bct_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    `BCT_ASSERT_NOW(a_min_range, m_tvalid, m_tdata[5:0] <= 6'd59, "minutes out of range")
    `BCT_ASSERT_NOW(a_sec_range, m_tvalid, m_tdata[11:6] <= 6'd59, "seconds out of range")
    // the alarm is only ever raised together with the led
    `BCT_ASSERT_NOW(a_alarm_led, m_tvalid && m_tdata[13], m_tdata[12], "alarm without led")
    `BCT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "stalled result word changed")

endmodule

bind button_countdown_timer bct_checker u_bct_checker (.*);
